FILE: hdl/rre_pkg.sv
// Shared constants, types and the arctangent table for the ray/border intersect block.
`default_nettype none
package rre_pkg;

	localparam int ANGLE_BITS      = 16;
	localparam int COORD_FRAC_BITS = 4;
	localparam int VIEW_BITS       = 13;
	localparam int OUT_BITS        = VIEW_BITS + COORD_FRAC_BITS;
	localparam int CORDIC_STEPS    = 24;
	localparam int TURN_BITS       = 32;
	// Q30 sine/cosine plus headroom and sign
	localparam int SC_W    = 33;
	localparam int MAG_W   = 32;
	localparam int PRD_W   = MAG_W + VIEW_BITS;
	localparam int SPRD_W  = SC_W + VIEW_BITS + 1;
	localparam int NUM_W   = SC_W + VIEW_BITS + 2;
	localparam int DVD_W   = NUM_W + COORD_FRAC_BITS + 1;
	localparam int DVS_W   = MAG_W + 1;
	localparam int QUO_W   = OUT_BITS + 1;
	localparam int REG_IDX_W = 1;

	typedef logic signed [SC_W-1:0] sc_t;

	localparam sc_t CORDIC_START = sc_t'(652032874);

	typedef enum logic [1:0] {
		EDGE_LEFT   = 2'd0,
		EDGE_RIGHT  = 2'd1,
		EDGE_TOP    = 2'd2,
		EDGE_BOTTOM = 2'd3
	} edge_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// arctan(2^-i) in 2^-32 turns
	function automatic sc_t atan_turn(input logic [4:0] i);
		sc_t v;
		unique case (i)
			5'd0:  v = sc_t'(536870912);
			5'd1:  v = sc_t'(316933406);
			5'd2:  v = sc_t'(167458907);
			5'd3:  v = sc_t'(85004756);
			5'd4:  v = sc_t'(42667331);
			5'd5:  v = sc_t'(21354465);
			5'd6:  v = sc_t'(10679838);
			5'd7:  v = sc_t'(5340245);
			5'd8:  v = sc_t'(2670163);
			5'd9:  v = sc_t'(1335087);
			5'd10: v = sc_t'(667544);
			5'd11: v = sc_t'(333772);
			5'd12: v = sc_t'(166886);
			5'd13: v = sc_t'(83443);
			5'd14: v = sc_t'(41722);
			5'd15: v = sc_t'(20861);
			5'd16: v = sc_t'(10430);
			5'd17: v = sc_t'(5215);
			5'd18: v = sc_t'(2608);
			5'd19: v = sc_t'(1304);
			5'd20: v = sc_t'(652);
			5'd21: v = sc_t'(326);
			5'd22: v = sc_t'(163);
			5'd23: v = sc_t'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/rre_if.sv
// Valid/ready channel interfaces for angle items and intersection result items.
`default_nettype none
interface rre_ang_if import rre_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] angle;
	modport source(output valid, angle, input ready);
	modport sink(input valid, angle, output ready);
endinterface

interface rre_res_if import rre_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                hit;
	logic [1:0]          edge_res;
	logic [OUT_BITS-1:0] point_x;
	logic [OUT_BITS-1:0] point_y;
	modport source(output valid, hit, edge_res, point_x, point_y, input ready);
	modport sink(input valid, hit, edge_res, point_x, point_y, output ready);
endinterface
`default_nettype wire

FILE: hdl/ray_rect_edge_intersect.sv
// Stages: input, CORDIC, quadrant fold, multiply, edge select, divider, output.
// Throughput: one item per cycle unless stalled; 24 CORDIC stages, 18-stage restoring
// divider, one iteration per stage, with a single advance enable for the whole pipe.
// A held result stalls every stage together; ready drops only while the output waits.
// Reset (arst_n low): all valid bits clear, viewport returns to 1920 x 1080.
// Configuration must only be written while the pipeline is empty.
`default_nettype none
module ray_rect_edge_intersect import rre_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire [REG_IDX_W-1:0] wr_index,
	input  wire [VIEW_BITS-1:0] wr_data,
	rre_ang_if.sink             ang,
	rre_res_if.source           res
);

	// viewport registers
	logic [VIEW_BITS-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= VIEW_BITS'(1920);
			height_q <= VIEW_BITS'(1080);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_WIDTH:  width_q  <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances when the output slot is free or being drained
	logic ov_q;
	logic en;
	assign en        = !ov_q || res.ready;
	assign ang.ready = en;

	// ---------------- CORDIC stages ----------------
	// entry 0 is loaded from the input; entry k+1 holds iteration k.
	sc_t        cx_s [CORDIC_STEPS+1];
	sc_t        cy_s [CORDIC_STEPS+1];
	sc_t        cz_s [CORDIC_STEPS+1];
	logic [1:0] cq_s [CORDIC_STEPS+1];
	logic       cv_s [CORDIC_STEPS+1];

	logic [TURN_BITS-1:0] turn;
	assign turn = TURN_BITS'(ang.angle) << (TURN_BITS - ANGLE_BITS);

	// quadrant fold stage
	sc_t              qs_s, qc_s;
	logic [MAG_W-1:0] qas_s, qac_s;
	logic             qv_s;

	// odd quadrants swap the roles of x and y
	sc_t fs_raw, fc_raw;
	assign fs_raw = cq_s[CORDIC_STEPS][0] ? cx_s[CORDIC_STEPS] : cy_s[CORDIC_STEPS];
	assign fc_raw = cq_s[CORDIC_STEPS][0] ? cy_s[CORDIC_STEPS] : cx_s[CORDIC_STEPS];

	// multiply stage
	logic [PRD_W-1:0]         m_acw_s, m_ash_s;
	logic signed [SPRD_W-1:0] m_cw_s, m_sh_s;
	logic [MAG_W-1:0]         m_as_s, m_ac_s;
	logic                     m_sneg_s, m_snz_s, m_cpos_s, m_cnz_s;
	logic                     mv_s;

	// edge select feeds divider entry 0; entry k+1 holds quotient bit QUO_W-1-k
	logic [DVD_W-1:0]    d_rem_s [QUO_W+1];
	logic [DVS_W-1:0]    d_dvs_s [QUO_W+1];
	logic [QUO_W-1:0]    d_quo_s [QUO_W+1];
	logic                d_hit_s [QUO_W+1];
	logic                d_lr_s  [QUO_W+1];
	edge_t               d_edge_s[QUO_W+1];
	logic [OUT_BITS-1:0] d_fix_s [QUO_W+1];
	logic                dv_s    [QUO_W+1];

	// output register
	logic                hit_q;
	logic [1:0]          edge_q;
	logic [OUT_BITS-1:0] px_q, py_q;

	// edge select logic
	logic signed [NUM_W-1:0] num_lr, num_tb, num_sel;
	logic                    sel_lr, sel_hit;
	logic [MAG_W-1:0]        sel_mag;
	logic [NUM_W-1:0]        num_pos;
	edge_t                   sel_edge;
	logic [OUT_BITS-1:0]     sel_fix;
	logic [DVD_W-1:0]        sel_dvd;
	logic [DVS_W-1:0]        sel_dvs;

	always_comb begin
		num_lr  = $signed(NUM_W'(m_ash_s)) - NUM_W'(m_cw_s);
		num_tb  = $signed(NUM_W'(m_acw_s)) + NUM_W'(m_sh_s);
		// corner rays fall to the side edges
		sel_lr  = m_snz_s && (m_acw_s <= m_ash_s);
		sel_hit = sel_lr || m_cnz_s;
		num_sel = sel_lr ? num_lr : num_tb;
		num_pos = num_sel[NUM_W-1] ? '0 : NUM_W'(num_sel);
		sel_mag = sel_lr ? m_as_s : m_ac_s;
		if (sel_lr) begin
			sel_edge = m_sneg_s ? EDGE_LEFT : EDGE_RIGHT;
			sel_fix  = m_sneg_s ? '0 : (OUT_BITS'(width_q) << COORD_FRAC_BITS);
		end else begin
			sel_edge = m_cpos_s ? EDGE_TOP : EDGE_BOTTOM;
			sel_fix  = m_cpos_s ? '0 : (OUT_BITS'(height_q) << COORD_FRAC_BITS);
		end
		// round half up: (num*2^F + d) / (2d)
		sel_dvd = (DVD_W'(num_pos) << COORD_FRAC_BITS) + DVD_W'(sel_mag);
		sel_dvs = DVS_W'(sel_mag) << 1;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CORDIC_STEPS; k++) cv_s[k] <= 1'b0;
			for (int k = 0; k <= QUO_W; k++) dv_s[k] <= 1'b0;
			qv_s <= 1'b0;
			mv_s <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			cv_s[0] <= ang.valid;
			for (int k = 0; k < CORDIC_STEPS; k++) cv_s[k+1] <= cv_s[k];
			qv_s    <= cv_s[CORDIC_STEPS];
			mv_s    <= qv_s;
			dv_s[0] <= mv_s;
			for (int k = 0; k < QUO_W; k++) dv_s[k+1] <= dv_s[k];
			ov_q    <= dv_s[QUO_W];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= CORDIC_START;
			cy_s[0] <= '0;
			cz_s[0] <= sc_t'(turn[TURN_BITS-3:0]);
			cq_s[0] <= turn[TURN_BITS-1:TURN_BITS-2];
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				if (cz_s[k] >= 0) begin
					cx_s[k+1] <= cx_s[k] - (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] + (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] - atan_turn(5'(k));
				end else begin
					cx_s[k+1] <= cx_s[k] + (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] - (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] + atan_turn(5'(k));
				end
				cq_s[k+1] <= cq_s[k];
			end

			// quadrant fold
			unique case (cq_s[CORDIC_STEPS])
				2'd0: begin
					qc_s <= cx_s[CORDIC_STEPS];
					qs_s <= cy_s[CORDIC_STEPS];
				end
				2'd1: begin
					qc_s <= -cy_s[CORDIC_STEPS];
					qs_s <= cx_s[CORDIC_STEPS];
				end
				2'd2: begin
					qc_s <= -cx_s[CORDIC_STEPS];
					qs_s <= -cy_s[CORDIC_STEPS];
				end
				default: begin
					qc_s <= cy_s[CORDIC_STEPS];
					qs_s <= -cx_s[CORDIC_STEPS];
				end
			endcase
			qas_s <= MAG_W'(fs_raw[SC_W-1] ? -fs_raw : fs_raw);
			qac_s <= MAG_W'(fc_raw[SC_W-1] ? -fc_raw : fc_raw);

			// products
			m_acw_s  <= PRD_W'(qac_s) * PRD_W'(width_q);
			m_ash_s  <= PRD_W'(qas_s) * PRD_W'(height_q);
			m_cw_s   <= SPRD_W'(qc_s) * $signed(SPRD_W'(width_q));
			m_sh_s   <= SPRD_W'(qs_s) * $signed(SPRD_W'(height_q));
			m_as_s   <= qas_s;
			m_ac_s   <= qac_s;
			m_sneg_s <= qs_s[SC_W-1];
			m_snz_s  <= (qs_s != '0);
			m_cpos_s <= !qc_s[SC_W-1] && (qc_s != '0);
			m_cnz_s  <= (qc_s != '0);

			// edge select
			d_rem_s[0]  <= sel_dvd;
			d_dvs_s[0]  <= sel_dvs;
			d_quo_s[0]  <= '0;
			d_hit_s[0]  <= sel_hit;
			d_lr_s[0]   <= sel_lr;
			d_edge_s[0] <= sel_edge;
			d_fix_s[0]  <= sel_fix;

			// restoring divider, one quotient bit per stage, msb first
			for (int k = 0; k < QUO_W; k++) begin
				if (d_rem_s[k] >= (DVD_W'(d_dvs_s[k]) << (QUO_W - 1 - k))) begin
					d_rem_s[k+1] <= d_rem_s[k] - (DVD_W'(d_dvs_s[k]) << (QUO_W - 1 - k));
					d_quo_s[k+1] <= d_quo_s[k] | (QUO_W'(1) << (QUO_W - 1 - k));
				end else begin
					d_rem_s[k+1] <= d_rem_s[k];
					d_quo_s[k+1] <= d_quo_s[k];
				end
				d_dvs_s[k+1]  <= d_dvs_s[k];
				d_hit_s[k+1]  <= d_hit_s[k];
				d_lr_s[k+1]   <= d_lr_s[k];
				d_edge_s[k+1] <= d_edge_s[k];
				d_fix_s[k+1]  <= d_fix_s[k];
			end

			// result; a miss reports all zeros
			hit_q <= d_hit_s[QUO_W];
			if (d_hit_s[QUO_W]) begin
				edge_q <= d_edge_s[QUO_W];
				px_q   <= d_lr_s[QUO_W] ? d_fix_s[QUO_W] : d_quo_s[QUO_W][OUT_BITS-1:0];
				py_q   <= d_lr_s[QUO_W] ? d_quo_s[QUO_W][OUT_BITS-1:0] : d_fix_s[QUO_W];
			end else begin
				edge_q <= EDGE_LEFT;
				px_q   <= '0;
				py_q   <= '0;
			end
		end
	end

	assign res.valid    = ov_q;
	assign res.hit      = hit_q;
	assign res.edge_res = edge_q;
	assign res.point_x  = px_q;
	assign res.point_y  = py_q;

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.hit) |-> (res.point_x == '0 && res.point_y == '0 &&
		res.edge_res == EDGE_LEFT))
		else $error("miss result not cleared");
	a_left_x: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.hit && res.edge_res == EDGE_LEFT) |-> (res.point_x == '0))
		else $error("left edge hit with nonzero x");
	a_top_y: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.hit && res.edge_res == EDGE_TOP) |-> (res.point_y == '0))
		else $error("top edge hit with nonzero y");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (ov_q && $stable(px_q) && $stable(py_q) && $stable(dv_s[QUO_W])))
		else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_ray_rect_edge_intersect.sv
// Self-checking bench for the ray/viewport border intersect block.
`default_nettype none
module tb_ray_rect_edge_intersect;
	import rre_pkg::*;

	// Expected hit point for one angle item.
	typedef struct packed {
		logic                hit;
		logic [1:0]          edge_res;
		logic [OUT_BITS-1:0] point_x;
		logic [OUT_BITS-1:0] point_y;
	} border_hit_t;

	// Holds the viewport size, predicts each border hit and checks it on arrival.
	class border_scoreboard;
		longint      vp_w;
		longint      vp_h;
		border_hit_t pending[$];
		int          errors;

		function new();
			vp_w = 1920;
			vp_h = 1080;
			errors = 0;
		endfunction

		// floor division by 2^n, also for negative values
		static function longint floor_shr(longint v, int n);
			longint r;
			if (v >= 0) r = v >>> n;
			else r = -((-(v + 1)) >>> n) - 1;
			return r;
		endfunction

		static function longint atan_step(int i);
			longint tbl[24] = '{536870912, 316933406, 167458907, 85004756,
				42667331, 21354465, 10679838, 5340245, 2670163, 1335087,
				667544, 333772, 166886, 83443, 41722, 20861, 10430, 5215,
				2608, 1304, 652, 326, 163, 81};
			return tbl[i];
		endfunction

		static function longint round_div(longint num, longint half_den);
			return ((num << COORD_FRAC_BITS) + half_den) / (2 * half_den);
		endfunction

		function border_hit_t predict(logic [ANGLE_BITS-1:0] ang);
			logic [31:0] turn;
			longint      x, y, z, dx, dy, sn, cs, as, ac, num;
			border_hit_t r;
			turn = {ang, {(32-ANGLE_BITS){1'b0}}};
			z = turn[29:0];
			x = 652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = floor_shr(y, i);
				dy = floor_shr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_step(i);
				end else begin
					x += dx; y -= dy; z += atan_step(i);
				end
			end
			case (turn[31:30])
				2'd0: begin cs = x;  sn = y;  end
				2'd1: begin cs = -y; sn = x;  end
				2'd2: begin cs = -x; sn = -y; end
				default: begin cs = y; sn = -x; end
			endcase
			as = (sn < 0) ? -sn : sn;
			ac = (cs < 0) ? -cs : cs;
			r = '0;
			if (sn != 0 && ac * vp_w <= as * vp_h) begin
				num = vp_h * as - cs * vp_w;
				if (num < 0) num = 0;
				r.hit = 1'b1;
				r.edge_res = (sn < 0) ? EDGE_LEFT : EDGE_RIGHT;
				r.point_x = (sn < 0) ? '0 : OUT_BITS'(vp_w << COORD_FRAC_BITS);
				r.point_y = OUT_BITS'(round_div(num, as));
			end else if (cs != 0) begin
				num = vp_w * ac + sn * vp_h;
				if (num < 0) num = 0;
				r.hit = 1'b1;
				r.edge_res = (cs > 0) ? EDGE_TOP : EDGE_BOTTOM;
				r.point_x = OUT_BITS'(round_div(num, ac));
				r.point_y = (cs > 0) ? '0 : OUT_BITS'(vp_h << COORD_FRAC_BITS);
			end
			return r;
		endfunction

		function void note_angle(logic [ANGLE_BITS-1:0] ang);
			pending.push_back(predict(ang));
		endfunction

		function void check_hit(border_hit_t got);
			border_hit_t e;
			if (pending.size() == 0) begin
				$error("unexpected result item %p", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.hit !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, got.hit); errors++;
			end
			if (got.edge_res !== e.edge_res) begin
				$error("edge_res: expected %0d, got %0d", e.edge_res, got.edge_res);
				errors++;
			end
			if (got.point_x !== e.point_x) begin
				$error("point_x: expected %0d, got %0d", e.point_x, got.point_x);
				errors++;
			end
			if (got.point_y !== e.point_y) begin
				$error("point_y: expected %0d, got %0d", e.point_y, got.point_y);
				errors++;
			end
		endfunction
	endclass

	localparam int DRAIN_CYCLES = CORDIC_STEPS + QUO_W + 20;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [VIEW_BITS-1:0] wr_data;

	rre_ang_if ang();
	rre_res_if res();

	ray_rect_edge_intersect uut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.ang(ang.sink), .res(res.source)
	);

	border_scoreboard sb;
	int  send_idle_pct;   // chance per cycle that the sender holds off
	int  recv_idle_pct;   // chance per cycle that the receiver stalls
	bit  recv_hold;       // long receiver stall in progress

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Generous cap; the slowest correct run is far below this.
	initial begin
		#2000000;
		$display("tb_ray_rect_edge_intersect: errors");
		$finish;
	end

	// Receiver: random stalls, plus an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check every accepted result item against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_hit({res.hit, res.edge_res, res.point_x, res.point_y});
	end

	// Offer one angle item, holding valid until it is taken.
	task automatic send_angle(logic [ANGLE_BITS-1:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			ang.valid <= 1'b0;
			@(posedge clk);
		end
		ang.valid <= 1'b1;
		ang.angle <= a;
		@(posedge clk);
		while (!ang.ready) @(posedge clk);
		sb.note_angle(a);
	endtask

	task automatic sender_rest();
		ang.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for the pipe to empty, then let the block settle.
	task automatic drain();
		ang.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [VIEW_BITS-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_WIDTH) sb.vp_w = val;
		else sb.vp_h = val;
		@(posedge clk);
	endtask

	// Mostly random sizes over the full range, sometimes the extremes or small ones.
	function automatic logic [VIEW_BITS-1:0] pick_size();
		case ($urandom_range(9))
			0: return VIEW_BITS'(1);
			1: return VIEW_BITS'(8191);
			2: return VIEW_BITS'($urandom_range(2, 16));
			default: return VIEW_BITS'($urandom_range(1, 8191));
		endcase
	endfunction

	// One in four near axes and diagonals, for edge choices and corners; rest random.
	function automatic logic [ANGLE_BITS-1:0] pick_angle();
		logic [ANGLE_BITS-1:0] base;
		case ($urandom_range(3))
			0: begin
				base = ANGLE_BITS'($urandom_range(7) << 13);
				return ANGLE_BITS'(base + ANGLE_BITS'($urandom_range(6)) - 3);
			end
			default: return ANGLE_BITS'($urandom);
		endcase
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) send_angle(pick_angle());
	endtask

	initial begin
		logic [ANGLE_BITS-1:0] directed[$];
		logic [VIEW_BITS-1:0]  ws[4];
		logic [VIEW_BITS-1:0]  hs[4];
		sb = new();
		arst_n = 1'b0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wr_en = 1'b0;
		wr_index = REG_WIDTH;
		wr_data = '0;
		ang.valid = 1'b0;
		ang.angle = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset size: axes, diagonals, field extremes, all bits.
		directed = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'h6000,
			16'hA000, 16'hE000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
			16'h3FFF, 16'h7FFF, 16'h8001, 16'hBFFF, 16'h1234, 16'hEDCB};
		foreach (directed[i]) send_angle(directed[i]);
		drain();

		// Degenerate and extreme viewports, including zero size.
		ws = '{13'd0, 13'd8191, 13'd1, 13'd8191};
		hs = '{13'd5, 13'd1, 13'd8191, 13'd8191};
		for (int k = 0; k < 4; k++) begin
			write_reg(REG_WIDTH, ws[k]);
			write_reg(REG_HEIGHT, hs[k]);
			for (int j = 0; j < 4; j++) send_angle(ANGLE_BITS'(16'h2000 * (2 * j + 1)));
			send_angle(16'h0000);
			send_angle(16'h4000);
			drain();
		end
		write_reg(REG_HEIGHT, 13'd0);
		send_angle(16'h1000);
		send_angle(16'h0000);
		drain();

		// Sender sparse, receiver stalling heavily.
		send_idle_pct = 19;
		recv_idle_pct = 75;
		for (int k = 0; k < 3; k++) begin
			write_reg(REG_WIDTH, pick_size());
			write_reg(REG_HEIGHT, pick_size());
			random_phase(70);
			drain();
		end

		// Long receiver hold-off while the sender keeps offering items.
		fork
			begin
				recv_hold <= 1'b1;
				repeat (150) @(posedge clk);
				recv_hold <= 1'b0;
			end
			random_phase(80);
		join
		// Sender pauses until everything is back.
		sender_rest();
		while (sb.pending.size() != 0) @(posedge clk);

		// Receiver sparse, sender idling heavily.
		send_idle_pct = 75;
		recv_idle_pct = 19;
		for (int k = 0; k < 2; k++) begin
			write_reg(REG_WIDTH, pick_size());
			write_reg(REG_HEIGHT, pick_size());
			random_phase(80);
			drain();
		end

		// Full rate both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_WIDTH, 13'd1920);
		write_reg(REG_HEIGHT, 13'd1080);
		random_phase(160);
		drain();

		if (sb.errors == 0)
			$display("tb_ray_rect_edge_intersect: clean");
		else
			$display("tb_ray_rect_edge_intersect: errors");
		$finish;
	end
endmodule
`default_nettype wire

FILE: ray_rect_edge_intersect.f
hdl/rre_pkg.sv
hdl/rre_if.sv
hdl/ray_rect_edge_intersect.sv
tb/tb_ray_rect_edge_intersect.sv
